// File: sv/mtep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared widths, status codes, result kinds, parse phases and record types.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 2;
  localparam int unsigned ChanW  = 4;
  localparam int unsigned Data7W = 7;
  localparam int unsigned TicksW = 21;
  localparam int unsigned TempoW = 24;
  localparam int unsigned CountW = 2;

  localparam logic [TempoW-1:0] TempoReset = 24'd55555;

  // Upper nibble of channel status bytes.
  localparam logic [3:0] HiNoteOff    = 4'h8;
  localparam logic [3:0] HiNoteOn     = 4'h9;
  localparam logic [3:0] HiPolyPress  = 4'hA;
  localparam logic [3:0] HiControl    = 4'hB;
  localparam logic [3:0] HiProgram    = 4'hC;
  localparam logic [3:0] HiChanPress  = 4'hD;
  localparam logic [3:0] HiPitchBend  = 4'hE;

  // Full status bytes and meta types.
  localparam logic [ByteW-1:0] StMeta      = 8'hFF;
  localparam logic [ByteW-1:0] StSysex     = 8'hF0;
  localparam logic [ByteW-1:0] StSysexEsc  = 8'hF7;
  localparam logic [ByteW-1:0] MetaTempo   = 8'd81;
  localparam logic [ByteW-1:0] MetaEnd     = 8'd47;

  typedef enum logic [KindW-1:0] {
    KIND_NOTE    = 2'd0,
    KIND_TEMPO   = 2'd1,
    KIND_END     = 2'd2,
    KIND_INVALID = 2'd3
  } mtep_kind_e;

  typedef enum logic [3:0] {
    PH_DELTA      = 4'd0,
    PH_STATUS     = 4'd1,
    PH_META_TYPE  = 4'd2,
    PH_LEN_SKIP   = 4'd3,
    PH_SKIP       = 4'd4,
    PH_TEMPO_LEN  = 4'd5,
    PH_TEMPO_DATA = 4'd6,
    PH_EOT_LEN    = 4'd7,
    PH_NOTE_KEY   = 4'd8,
    PH_NOTE_VEL   = 4'd9
  } mtep_phase_e;

  typedef struct packed {
    mtep_kind_e        kind;
    logic [ChanW-1:0]  channel;
    logic [Data7W-1:0] key;
    logic [Data7W-1:0] velocity;
    logic [TicksW-1:0] wait_ticks;
    logic [TicksW-1:0] hold_ticks;
    logic [TempoW-1:0] tempo;
  } mtep_result_t;

endpackage

// File: sv/mtep_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser channels
// Valid/ready channels for the byte input and the event result output.
// ----------------------------------------------------------------------------
interface mtep_in_if import mtep_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             track_start;

  modport source (output valid, output data_byte, output track_start, input ready);
  modport sink   (input valid, input data_byte, input track_start, output ready);
endinterface

interface mtep_out_if import mtep_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [ChanW-1:0]  channel;
  logic [Data7W-1:0] key;
  logic [Data7W-1:0] velocity;
  logic [TicksW-1:0] wait_ticks;
  logic [TicksW-1:0] hold_ticks;
  logic [TempoW-1:0] tempo;

  modport source (output valid, output kind, output channel, output key, output velocity,
                  output wait_ticks, output hold_ticks, output tempo, input ready);
  modport sink   (input valid, input kind, input channel, input key, input velocity,
                  input wait_ticks, input hold_ticks, input tempo, output ready);
endinterface

// File: sv/mtep_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser core
// Per-byte parse state machine, note tracking and tempo register.
// ----------------------------------------------------------------------------
module mtep_core import mtep_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             track_start_i,
  output logic             res_valid_o,
  output mtep_result_t     res_o
);

  mtep_phase_e       phase_q, phase_d, phase_e;
  logic [TicksW-1:0] acc_q, acc_d, acc_e, acc_shift;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_e;
  logic [TicksW-1:0] delta_q, delta_d, delta_e;
  logic [ByteW-1:0]  status_q, status_d, status_e;
  logic [Data7W-1:0] first_q, first_d, first_e;
  logic [ByteW-1:0]  skip_q, skip_d, skip_e, skip_dec;
  logic [TempoW-1:0] tacc_q, tacc_d, tacc_e, tacc_shift;
  logic [TempoW-1:0] tempo_q, tempo_d;
  logic              active_q, active_d, active_e;
  logic [ChanW-1:0]  hchan_q, hchan_d, hchan_e;
  logic [Data7W-1:0] hkey_q, hkey_d, hkey_e;
  logic [Data7W-1:0] hvel_q, hvel_d, hvel_e;
  logic [TicksW-1:0] hwait_q, hwait_d, hwait_e;
  logic              ended_q, ended_d, ended_e;
  logic [3:0]        hi;
  logic              emit;
  mtep_kind_e        emit_kind;

  always_comb begin
    // A track start clears everything except the tempo before the byte is parsed.
    if (track_start_i) begin
      phase_e  = PH_DELTA;
      acc_e    = '0;
      cnt_e    = '0;
      delta_e  = '0;
      status_e = '0;
      first_e  = '0;
      skip_e   = '0;
      tacc_e   = '0;
      active_e = 1'b0;
      hchan_e  = '0;
      hkey_e   = '0;
      hvel_e   = '0;
      hwait_e  = '0;
      ended_e  = 1'b0;
    end else begin
      phase_e  = phase_q;
      acc_e    = acc_q;
      cnt_e    = cnt_q;
      delta_e  = delta_q;
      status_e = status_q;
      first_e  = first_q;
      skip_e   = skip_q;
      tacc_e   = tacc_q;
      active_e = active_q;
      hchan_e  = hchan_q;
      hkey_e   = hkey_q;
      hvel_e   = hvel_q;
      hwait_e  = hwait_q;
      ended_e  = ended_q;
    end

    hi         = data_byte_i[7:4];
    acc_shift  = {acc_e[TicksW-8:0], data_byte_i[6:0]};
    tacc_shift = {tacc_e[TempoW-9:0], data_byte_i};
    skip_dec   = (skip_e != '0) ? skip_e - 8'd1 : skip_e;
    emit       = 1'b0;
    emit_kind  = KIND_NOTE;

    phase_d  = phase_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    delta_d  = delta_q;
    status_d = status_q;
    first_d  = first_q;
    skip_d   = skip_q;
    tacc_d   = tacc_q;
    tempo_d  = tempo_q;
    active_d = active_q;
    hchan_d  = hchan_q;
    hkey_d   = hkey_q;
    hvel_d   = hvel_q;
    hwait_d  = hwait_q;
    ended_d  = ended_q;

    if (accept_i) begin
      phase_d  = phase_e;
      acc_d    = acc_e;
      cnt_d    = cnt_e;
      delta_d  = delta_e;
      status_d = status_e;
      first_d  = first_e;
      skip_d   = skip_e;
      tacc_d   = tacc_e;
      active_d = active_e;
      hchan_d  = hchan_e;
      hkey_d   = hkey_e;
      hvel_d   = hvel_e;
      hwait_d  = hwait_e;
      ended_d  = ended_e;

      if (!ended_e) begin
        case (phase_e)
          PH_DELTA: begin
            // The third byte always ends the number whatever its top bit.
            if (data_byte_i[7] && (cnt_e < 2'd2)) begin
              acc_d = acc_shift;
              cnt_d = cnt_e + 2'd1;
            end else begin
              delta_d = acc_shift;
              acc_d   = '0;
              cnt_d   = '0;
              phase_d = PH_STATUS;
            end
          end
          PH_STATUS: begin
            status_d = data_byte_i;
            if (!data_byte_i[7]) begin
              phase_d   = PH_DELTA;
              emit      = 1'b1;
              emit_kind = KIND_INVALID;
            end else if (hi == HiNoteOff || hi == HiNoteOn) begin
              phase_d = PH_NOTE_KEY;
            end else if (hi == HiPolyPress || hi == HiControl || hi == HiPitchBend) begin
              skip_d  = 8'd2;
              phase_d = PH_SKIP;
            end else if (hi == HiProgram || hi == HiChanPress) begin
              skip_d  = 8'd1;
              phase_d = PH_SKIP;
            end else if (data_byte_i == StMeta) begin
              phase_d = PH_META_TYPE;
            end else if (data_byte_i == StSysex || data_byte_i == StSysexEsc) begin
              phase_d = PH_LEN_SKIP;
            end else begin
              phase_d = PH_DELTA;
            end
          end
          PH_META_TYPE: begin
            if (data_byte_i == MetaTempo) begin
              phase_d = PH_TEMPO_LEN;
            end else if (data_byte_i == MetaEnd) begin
              phase_d = PH_EOT_LEN;
            end else begin
              phase_d = PH_LEN_SKIP;
            end
          end
          PH_LEN_SKIP: begin
            skip_d  = data_byte_i;
            phase_d = (data_byte_i == '0) ? PH_DELTA : PH_SKIP;
          end
          PH_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == '0) begin
              phase_d = PH_DELTA;
            end
          end
          PH_TEMPO_LEN: begin
            // The length byte is not checked; three tempo bytes always follow.
            tacc_d  = '0;
            cnt_d   = '0;
            phase_d = PH_TEMPO_DATA;
          end
          PH_TEMPO_DATA: begin
            tacc_d = tacc_shift;
            if (cnt_e < 2'd2) begin
              cnt_d = cnt_e + 2'd1;
            end else begin
              cnt_d     = '0;
              tempo_d   = tacc_shift;
              phase_d   = PH_DELTA;
              emit      = 1'b1;
              emit_kind = KIND_TEMPO;
            end
          end
          PH_EOT_LEN: begin
            ended_d   = 1'b1;
            phase_d   = PH_DELTA;
            emit      = 1'b1;
            emit_kind = KIND_END;
          end
          PH_NOTE_KEY: begin
            first_d = data_byte_i[6:0];
            phase_d = PH_NOTE_VEL;
          end
          PH_NOTE_VEL: begin
            phase_d = PH_DELTA;
            if (status_e[7:4] == HiNoteOn) begin
              if (!active_e) begin
                active_d = 1'b1;
                hchan_d  = status_e[3:0];
                hkey_d   = first_e;
                hwait_d  = delta_e;
              end
              hvel_d = data_byte_i[6:0];
            end else if (active_e && (first_e == hkey_e) && (status_e[3:0] == hchan_e)) begin
              active_d  = 1'b0;
              emit      = 1'b1;
              emit_kind = KIND_NOTE;
            end
          end
          default: begin
            phase_d = PH_DELTA;
          end
        endcase
      end
    end

    res_valid_o = emit;
    res_o       = '0;
    res_o.kind  = emit_kind;
    res_o.tempo = tempo_d;
    if (emit_kind == KIND_NOTE) begin
      res_o.channel    = hchan_e;
      res_o.key        = hkey_e;
      res_o.velocity   = hvel_e;
      res_o.wait_ticks = hwait_e;
      res_o.hold_ticks = delta_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DELTA;
      acc_q    <= '0;
      cnt_q    <= '0;
      delta_q  <= '0;
      status_q <= '0;
      first_q  <= '0;
      skip_q   <= '0;
      tacc_q   <= '0;
      tempo_q  <= TempoReset;
      active_q <= 1'b0;
      hchan_q  <= '0;
      hkey_q   <= '0;
      hvel_q   <= '0;
      hwait_q  <= '0;
      ended_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      delta_q  <= delta_d;
      status_q <= status_d;
      first_q  <= first_d;
      skip_q   <= skip_d;
      tacc_q   <= tacc_d;
      tempo_q  <= tempo_d;
      active_q <= active_d;
      hchan_q  <= hchan_d;
      hkey_q   <= hkey_d;
      hvel_q   <= hvel_d;
      hwait_q  <= hwait_d;
      ended_q  <= ended_d;
    end
  end

endmodule

// File: sv/midi_track_event_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI track event parser
// Bytes of one track's events go in on in_i, one per transaction. Each byte
// is parsed in the cycle it is accepted, and the event it completes, if any,
// is loaded into an output register and offered on out_o: a note record
// when the held note's note-off arrives, a tempo change, end of track or an
// invalid status byte. Most bytes complete nothing and produce no result.
// out_o.valid rises at the accepting edge. Throughput is one byte per cycle
// unless out_o stalls; the parse state fits in one register stage.
// in_i.ready is high whenever the output register is empty or being drained
// this cycle, so a byte is taken while a finished result is handed over.
// When the receiver stalls with a result pending, in_i.ready drops and the
// byte stream waits; no result is lost. After end of track all bytes are
// taken and ignored until one arrives with track_start set. Reset empties
// the output register, returns the parser to expect a delta time, drops
// any held note and sets the tempo to 55555 microseconds per quarter note.
// ----------------------------------------------------------------------------
module midi_track_event_parser import mtep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtep_in_if.sink     in_i,
  mtep_out_if.source  out_o
);

  logic         accept;
  logic         res_valid;
  mtep_result_t res;
  logic         out_valid_q, out_valid_d;
  mtep_result_t out_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  mtep_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (in_i.data_byte),
    .track_start_i (in_i.track_start),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.channel    = out_q.channel;
  assign out_o.key        = out_q.key;
  assign out_o.velocity   = out_q.velocity;
  assign out_o.wait_ticks = out_q.wait_ticks;
  assign out_o.hold_ticks = out_q.hold_ticks;
  assign out_o.tempo      = out_q.tempo;

endmodule
